[rtl/core/sact_pkg.sv]
// Shared types and constants of the cache tag store.
package sact_pkg;

  localparam int unsigned ADDR_W = 32;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_OFFSET_BITS = 3'd0,
    REG_INDEX_BITS  = 3'd1,
    REG_WAYS        = 3'd2,
    REG_LRU         = 3'd3,
    REG_WALLOC      = 3'd4,
    REG_WBACK       = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [3:0] offset_bits;
    logic [3:0] index_bits;
    logic [3:0] ways_in_use;
    logic       lru_mode;
    logic       write_allocate;
    logic       write_back;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_RESOLVE,
    BK_CLEAR
  } bk_state_t;

endpackage

[rtl/core/sact_front.sv]
// Front end: accepts accesses, splits the address and queues set, tag and kind.
module sact_front #(
  parameter int unsigned SET_W = 8,
  parameter int unsigned IDX_MAX = 8,
  parameter int unsigned Q_DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sact_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic [sact_pkg::ADDR_W-1:0] in_addr,
  output logic                        q_valid,
  input  logic                        q_pop,
  output logic                        q_store,
  output logic [SET_W-1:0]            q_set,
  output logic [sact_pkg::ADDR_W-1:0] q_tag
);

  localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned ENT_W = 1 + SET_W + sact_pkg::ADDR_W;

  logic [ENT_W-1:0]  q_mem_r [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]    count_r;
  logic [3:0]        ib;
  logic [4:0]        sh;
  logic [sact_pkg::ADDR_W-1:0] shifted;
  logic [SET_W-1:0]  set_v;
  logic [sact_pkg::ADDR_W-1:0] tag_v;
  logic              push;
  logic [ENT_W-1:0]  head;

  // Limit the index width to what the set store can hold
  always_comb begin
    ib = cfg.index_bits;
    if ({28'd0, ib} > IDX_MAX) ib = 4'(IDX_MAX);
    sh = 5'(cfg.offset_bits) + 5'(ib);
    shifted = in_addr >> cfg.offset_bits;
    set_v = SET_W'(shifted & ((sact_pkg::ADDR_W'(1) << ib) - sact_pkg::ADDR_W'(1)));
    tag_v = 32'((33'(in_addr)) >> sh);
  end

  assign in_ready = (count_r != (PTR_W+1)'(Q_DEPTH));
  assign push = in_valid && in_ready;
  assign q_valid = (count_r != '0);
  assign head = q_mem_r[rd_ptr_r];
  assign q_store = head[ENT_W-1];
  assign q_set = head[ENT_W-2 -: SET_W];
  assign q_tag = head[sact_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= {in_cmd, set_v, tag_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      count_r <= count_r + (PTR_W+1)'(push) - (PTR_W+1)'(q_pop);
    end
  end

endmodule

[rtl/core/sact_back.sv]
// Back end: reads a set, resolves hit or victim, writes the set and emits the result.
module sact_back #(
  parameter int unsigned SET_W = 8,
  parameter int unsigned MAX_WAYS = 8,
  parameter int unsigned MEM_PENALTY = 100
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sact_pkg::cfg_t              cfg,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  logic                        q_store,
  input  logic [SET_W-1:0]            q_set,
  input  logic [sact_pkg::ADDR_W-1:0] q_tag,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [13:0]                 out_data,
  output logic                        busy
);

  localparam int unsigned SETS = 1 << SET_W;
  localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned C1 = (1 + MEM_PENALTY > 255) ? 255 : 1 + MEM_PENALTY;
  localparam int unsigned C2 = (1 + 2*MEM_PENALTY > 255) ? 255 : 1 + 2*MEM_PENALTY;

  // Tag and stamp memories, one word per set holding all ways
  logic [MAX_WAYS*32-1:0] tag_mem   [SETS];
  logic [MAX_WAYS*32-1:0] stamp_mem [SETS];
  logic [MAX_WAYS*32-1:0] tag_rd_r, stamp_rd_r;
  logic [MAX_WAYS-1:0]    valid_mem [SETS];
  logic [MAX_WAYS-1:0]    dirty_mem [SETS];
  logic [MAX_WAYS-1:0]    vrow_r, drow_r;

  sact_pkg::bk_state_t st_r, st_nxt;
  logic [SET_W-1:0]  clr_r;
  logic [31:0]       cnt_r;
  logic              store_r;
  logic [SET_W-1:0]  set_r;
  logic [31:0]       tag_r;
  logic              ov_r;
  logic [13:0]       od_r;

  logic [3:0]        ways;
  logic              hit, fill, evict, hit_found, inv_found;
  logic [WAY_W-1:0]  hit_w, inv_w, old_w, vic_w, sel_w;
  logic [31:0]       best_age, age;
  logic              wr_en, wr_tag, wr_stamp;
  logic [MAX_WAYS-1:0] vrow_nxt, drow_nxt;
  logic [7:0]        cost;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      sact_pkg::BK_IDLE:    if (q_valid && !ov_r) st_nxt = sact_pkg::BK_READ;
      sact_pkg::BK_READ:    st_nxt = sact_pkg::BK_RESOLVE;
      sact_pkg::BK_RESOLVE: st_nxt = sact_pkg::BK_IDLE;
      sact_pkg::BK_CLEAR:   if (clr_r == SET_W'(SETS-1)) st_nxt = sact_pkg::BK_IDLE;
      default:              st_nxt = sact_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (st_r == sact_pkg::BK_IDLE) && q_valid && !ov_r;
    wr_en = (st_r == sact_pkg::BK_RESOLVE);
  end

  // Way search over the registered set row
  always_comb begin
    ways = cfg.ways_in_use;
    if (ways == 4'd0) ways = 4'd1;
    if ({28'd0, ways} > MAX_WAYS) ways = 4'(MAX_WAYS);
    hit_found = 1'b0; hit_w = '0;
    inv_found = 1'b0; inv_w = '0;
    old_w = '0; best_age = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      age = cnt_r - stamp_rd_r[w*32 +: 32];
      if (w < ways) begin
        if (!hit_found && vrow_r[w] && tag_rd_r[w*32 +: 32] == tag_r) begin
          hit_found = 1'b1; hit_w = WAY_W'(w);
        end
        if (!inv_found && !vrow_r[w]) begin
          inv_found = 1'b1; inv_w = WAY_W'(w);
        end
        if (w == 0 || age > best_age) begin
          best_age = age; old_w = WAY_W'(w);
        end
      end
    end
    hit = hit_found;
    vic_w = inv_found ? inv_w : old_w;
    fill = !hit && (!store_r || cfg.write_allocate);
    evict = fill && vrow_r[vic_w] && drow_r[vic_w];
    sel_w = hit ? hit_w : (fill ? vic_w : '0);
    wr_tag = fill;
    wr_stamp = fill || (hit && cfg.lru_mode);
    vrow_nxt = vrow_r;
    drow_nxt = drow_r;
    if (hit && store_r && cfg.write_back) drow_nxt[hit_w] = 1'b1;
    if (fill) begin
      vrow_nxt[vic_w] = 1'b1;
      drow_nxt[vic_w] = store_r && cfg.write_back;
    end
    cost = hit ? 8'd1 : (evict ? 8'(C2) : 8'(C1));
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      store_r <= q_store;
      set_r   <= q_set;
      tag_r   <= q_tag;
    end
    if (st_r == sact_pkg::BK_READ) begin
      tag_rd_r   <= tag_mem[set_r];
      stamp_rd_r <= stamp_mem[set_r];
      vrow_r     <= valid_mem[set_r];
      drow_r     <= dirty_mem[set_r];
    end
    // Zero one set per cycle after reset, else write back the resolved set
    if (st_r == sact_pkg::BK_CLEAR) begin
      valid_mem[clr_r] <= '0;
      dirty_mem[clr_r] <= '0;
    end else if (wr_en) begin
      valid_mem[set_r] <= vrow_nxt;
      dirty_mem[set_r] <= drow_nxt;
    end
    if (wr_en && wr_tag) tag_mem[set_r][sel_w*32 +: 32] <= tag_r;
    if (wr_en && wr_stamp) stamp_mem[set_r][sel_w*32 +: 32] <= cnt_r;
    if (wr_en) od_r <= {cost, 3'(sel_w), evict, fill, hit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= sact_pkg::BK_CLEAR;
      clr_r <= '0;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == sact_pkg::BK_CLEAR) clr_r <= clr_r + 1'b1;
      if (wr_en) begin
        cnt_r <= cnt_r + 32'd1;
        ov_r  <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign busy = (st_r != sact_pkg::BK_IDLE);

endmodule

[rtl/core/set_assoc_cache_tag_store.sv]
// Top level of the set-associative cache tag store.
// Each access is looked up in one set: the back end pops it from the queue, reads the set's
// tags, stamps, valid and dirty bits in the next cycle, resolves hit or victim and writes the
// set back in the cycle after, and then hands the result register over, taking no new access
// while a result waits. A two-entry queue lets new accesses be taken while a result waits.
// After reset a clearing pass zeroes the valid and dirty bits of one set per cycle over all
// 2^SET_W sets (256 by default); accesses taken meanwhile wait in the queue.
module set_assoc_cache_tag_store #(
  parameter int unsigned MAX_SETS = 256,
  parameter int unsigned MAX_WAYS = 8,
  parameter int unsigned MEM_PENALTY = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // address[31:0]
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // hit, filled, dirty_evict, way[2:0], cost_cycles[7:0], zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Largest index width whose sets all fit in MAX_SETS
  localparam int unsigned IDX_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int unsigned SET_W = (IDX_MAX > 0) ? IDX_MAX : 1;

  sact_pkg::cfg_t cfg_r;
  logic           q_valid, q_pop, q_store, busy;
  logic [SET_W-1:0] q_set;
  logic [31:0]    q_tag;
  logic [13:0]    od;
  logic [2:0]     ridx;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{offset_bits: 4'd4, index_bits: 4'd4, ways_in_use: 4'd1,
                 lru_mode: 1'b1, write_allocate: 1'b1, write_back: 1'b1};
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (ridx)
        sact_pkg::REG_OFFSET_BITS: cfg_r.offset_bits    <= cfg_pwdata[3:0];
        sact_pkg::REG_INDEX_BITS:  cfg_r.index_bits     <= cfg_pwdata[3:0];
        sact_pkg::REG_WAYS:        cfg_r.ways_in_use    <= cfg_pwdata[3:0];
        sact_pkg::REG_LRU:         cfg_r.lru_mode       <= cfg_pwdata[0];
        sact_pkg::REG_WALLOC:      cfg_r.write_allocate <= cfg_pwdata[0];
        sact_pkg::REG_WBACK:       cfg_r.write_back     <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'b00) begin
      case (ridx)
        sact_pkg::REG_OFFSET_BITS: cfg_prdata = {28'd0, cfg_r.offset_bits};
        sact_pkg::REG_INDEX_BITS:  cfg_prdata = {28'd0, cfg_r.index_bits};
        sact_pkg::REG_WAYS:        cfg_prdata = {28'd0, cfg_r.ways_in_use};
        sact_pkg::REG_LRU:         cfg_prdata = {31'd0, cfg_r.lru_mode};
        sact_pkg::REG_WALLOC:      cfg_prdata = {31'd0, cfg_r.write_allocate};
        sact_pkg::REG_WBACK:       cfg_prdata = {31'd0, cfg_r.write_back};
        default:                   cfg_prdata = '0;
      endcase
    end
  end

  sact_front #(.SET_W(SET_W), .IDX_MAX(IDX_MAX), .Q_DEPTH(2)) u_front (
    .clk, .rst_n, .cfg(cfg_r),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_cmd(in_tuser), .in_addr(in_tdata),
    .q_valid, .q_pop, .q_store, .q_set, .q_tag
  );

  sact_back #(.SET_W(SET_W), .MAX_WAYS(MAX_WAYS), .MEM_PENALTY(MEM_PENALTY)) u_back (
    .clk, .rst_n, .cfg(cfg_r),
    .q_valid, .q_pop, .q_store, .q_set, .q_tag,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(od), .busy
  );

  assign out_tdata = {2'd0, od};

  // A hit never fills and never writes back
  a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && (out_tdata[1] || out_tdata[2])))
    else $error("hit with fill or writeback");

  // A writeback only comes with a fill
  a_evict_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1])
    else $error("writeback without fill");

  // The queue is popped only while the back end is idle
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !busy && !out_tvalid)
    else $error("pop while busy");

endmodule
